// File: sv/rgb_ycbcr_color_converter_macros.svh
// Assertion macros shared by the converter checker
`ifndef RGB_YCBCR_COLOR_CONVERTER_MACROS_SVH
`define RGB_YCBCR_COLOR_CONVERTER_MACROS_SVH

// Property must hold at every clock edge outside reset
`define RYC_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("converter check failed");

// Consequent must hold in the same cycle as the antecedent
`define RYC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("converter check failed");

`endif

// File: sv/ryc_pkg.sv
// Shared types and constants of the color converter
package ryc_pkg;

  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int PIX_W = 8;
  // signed operand: 8-bit component or component minus 128
  localparam int OPND_W = PIX_W + 2;
  localparam int PIPE_DEPTH = 4;
  localparam int PADDR_W = 3;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic {
    DIR_RGB2YCC = 1'b0,
    DIR_YCC2RGB = 1'b1
  } dir_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DIRECTION = 1'b0,
    REG_NONE      = 1'b1
  } reg_idx_t;

endpackage

// File: sv/rgb_ycbcr_color_converter.sv
// Top level of the JFIF RGB / YCbCr pixel converter
//
//  channel   signals                                 direction
//  input     start, in_c0..in_c2 (busy out of block)    into block
//  result    done, out_c0..out_c2                     out of block
//  config    psel, penable, pwrite, paddr, pwdata,    APB slave
//            prdata, pready
//
// Every pixel passes from start to done through the operand register,
// multiplier register, adder register and saturate register, in that order.
// busy stays low; a new pixel enters every cycle.
// rst clears the valid bits of all four stages and sets direction to RGB to YCbCr.
// The receiver takes done as it comes, so the pipeline never stalls.
module rgb_ycbcr_color_converter import ryc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pix_t               in_c0,
  input  pix_t               in_c1,
  input  pix_t               in_c2,
  output logic               done,
  output pix_t               out_c0,
  output pix_t               out_c1,
  output pix_t               out_c2,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int PW = COEF_FRAC_BITS + 2 + OPND_W;
  localparam int SW = PW + 2;

  dir_t                 direction;
  reg_idx_t             reg_idx;
  logic                 in_fire;
  logic                 mul_valid;
  dir_t                 mul_dir;
  logic signed [PW-1:0] prod [3][3];
  logic                 sum_valid;
  logic signed [SW-1:0] sum [3];
  pix_t                 pix [3];

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign in_fire = start && !busy;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_RGB2YCC;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_DIRECTION) begin
      direction <= dir_t'(pwdata[0]);
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIRECTION: prdata = {31'b0, direction};
      default:       prdata = '0;
    endcase
  end

  ryc_mul #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_fire),
    .dir       (direction),
    .a         (in_c0),
    .b         (in_c1),
    .c         (in_c2),
    .out_valid (mul_valid),
    .out_dir   (mul_dir),
    .prod      (prod)
  );

  ryc_sum #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .dir       (mul_dir),
    .prod      (prod),
    .out_valid (sum_valid),
    .sum       (sum)
  );

  ryc_sat #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .sum       (sum),
    .out_valid (done),
    .pix       (pix)
  );

  assign out_c0 = pix[0];
  assign out_c1 = pix[1];
  assign out_c2 = pix[2];

endmodule

// File: sv/ryc_mul.sv
// Operand stage and coefficient multiplier stage
module ryc_mul import ryc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int CW = COEF_FRAC_BITS + 2,
  localparam int PW = CW + OPND_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  dir_t                 dir,
  input  pix_t                 a,
  input  pix_t                 b,
  input  pix_t                 c,
  output logic                 out_valid,
  output dir_t                 out_dir,
  output logic signed [PW-1:0] prod [3][3]
);

  localparam longint unsigned SCALE = 64'd1 << COEF_FRAC_BITS;
  localparam longint unsigned K_Y_R  = (299 * SCALE + 500) / 1000;
  localparam longint unsigned K_Y_G  = (587 * SCALE + 500) / 1000;
  localparam longint unsigned K_Y_B  = (114 * SCALE + 500) / 1000;
  localparam longint unsigned K_CB_R = (168736 * SCALE + 500000) / 1000000;
  localparam longint unsigned K_CB_G = (331264 * SCALE + 500000) / 1000000;
  localparam longint unsigned K_CR_G = (418688 * SCALE + 500000) / 1000000;
  localparam longint unsigned K_CR_B = (81312 * SCALE + 500000) / 1000000;
  localparam longint unsigned K_R_CR = (1402 * SCALE + 500) / 1000;
  localparam longint unsigned K_G_CB = (34414 * SCALE + 50000) / 100000;
  localparam longint unsigned K_G_CR = (71414 * SCALE + 50000) / 100000;
  localparam longint unsigned K_B_CB = (1772 * SCALE + 500) / 1000;
  localparam longint unsigned K_HALF = SCALE >> 1;

  localparam logic signed [CW-1:0] C_YR  = CW'(K_Y_R);
  localparam logic signed [CW-1:0] C_YG  = CW'(K_Y_G);
  localparam logic signed [CW-1:0] C_YB  = CW'(K_Y_B);
  localparam logic signed [CW-1:0] C_CBR = -CW'(K_CB_R);
  localparam logic signed [CW-1:0] C_CBG = -CW'(K_CB_G);
  localparam logic signed [CW-1:0] C_CRG = -CW'(K_CR_G);
  localparam logic signed [CW-1:0] C_CRB = -CW'(K_CR_B);
  localparam logic signed [CW-1:0] C_RCR = CW'(K_R_CR);
  localparam logic signed [CW-1:0] C_GCB = -CW'(K_G_CB);
  localparam logic signed [CW-1:0] C_GCR = -CW'(K_G_CR);
  localparam logic signed [CW-1:0] C_BCB = CW'(K_B_CB);
  localparam logic signed [CW-1:0] C_HALF = CW'(K_HALF);
  localparam logic signed [CW-1:0] C_ONE  = CW'(SCALE);
  localparam logic signed [CW-1:0] C_ZERO = '0;

  localparam logic signed [OPND_W-1:0] CHROMA_OFS = OPND_W'(128);

  logic                     op_valid;
  dir_t                     op_dir;
  logic signed [OPND_W-1:0] op [3];
  logic signed [CW-1:0]     coef [3][3];

  // stage 1: register operands, remove chroma offset for the inverse
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    op_dir <= dir;
    op[0]  <= $signed({2'b00, a});
    if (dir == DIR_YCC2RGB) begin
      op[1] <= $signed({2'b00, b}) - CHROMA_OFS;
      op[2] <= $signed({2'b00, c}) - CHROMA_OFS;
    end else begin
      op[1] <= $signed({2'b00, b});
      op[2] <= $signed({2'b00, c});
    end
  end

  always_comb begin
    unique case (op_dir)
      DIR_RGB2YCC: begin
        coef[0][0] = C_YR;   coef[0][1] = C_YG;   coef[0][2] = C_YB;
        coef[1][0] = C_CBR;  coef[1][1] = C_CBG;  coef[1][2] = C_HALF;
        coef[2][0] = C_HALF; coef[2][1] = C_CRG;  coef[2][2] = C_CRB;
      end
      DIR_YCC2RGB: begin
        coef[0][0] = C_ONE;  coef[0][1] = C_ZERO; coef[0][2] = C_RCR;
        coef[1][0] = C_ONE;  coef[1][1] = C_GCB;  coef[1][2] = C_GCR;
        coef[2][0] = C_ONE;  coef[2][1] = C_BCB;  coef[2][2] = C_ZERO;
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            coef[i][j] = C_ZERO;
          end
        end
      end
    endcase
  end

  // stage 2: one registered product per coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_dir <= op_dir;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod[i][j] <= PW'(coef[i][j]) * PW'(op[j]);
      end
    end
  end

endmodule

// File: sv/ryc_sum.sv
// Adder stage: three products per output, plus the chroma offset on Cb and Cr for RGB to YCbCr
module ryc_sum import ryc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int PW = COEF_FRAC_BITS + 2 + OPND_W,
  localparam int SW = PW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  dir_t                 dir,
  input  logic signed [PW-1:0] prod [3][3],
  output logic                 out_valid,
  output logic signed [SW-1:0] sum [3]
);

  localparam logic signed [SW-1:0] OFS_128 = SW'(longint'(128) << COEF_FRAC_BITS);

  logic signed [SW-1:0] ofs [3];

  always_comb begin
    ofs[0] = '0;
    ofs[1] = (dir == DIR_RGB2YCC) ? OFS_128 : '0;
    ofs[2] = (dir == DIR_RGB2YCC) ? OFS_128 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sum[i] <= SW'(prod[i][0]) + SW'(prod[i][1]) + SW'(prod[i][2]) + ofs[i];
    end
  end

endmodule

// File: sv/ryc_sat.sv
// Output stage: floor to integer and clamp to 0..255
module ryc_sat import ryc_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int SW = COEF_FRAC_BITS + 4 + OPND_W,
  localparam int IW = SW - COEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [SW-1:0] sum [3],
  output logic                 out_valid,
  output pix_t                 pix [3]
);

  localparam logic [IW-1:0] PIX_MAX = IW'(255);

  logic [IW-1:0] whole [3];
  pix_t          pix_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // drop the fraction: floor for non-negative sums
      whole[i] = sum[i][SW-1:COEF_FRAC_BITS];
      if (sum[i][SW-1]) begin
        pix_next[i] = '0;
      end else if (whole[i] > PIX_MAX) begin
        pix_next[i] = '1;
      end else begin
        pix_next[i] = whole[i][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    pix <= pix_next;
  end

endmodule

// File: sv/ryc_checker.sv
// Port-level checks of the converter and their binding to the top level
`include "rgb_ycbcr_color_converter_macros.svh"

module ryc_checker import ryc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic pready
);

  // pipeline takes a pixel every cycle
  `RYC_ASSERT_ALWAYS(a_never_busy, clk, rst, !busy)

  `RYC_ASSERT_ALWAYS(a_pready_high, clk, rst, pready)

  // each transaction comes out once as done, and done never rises without a transaction
  `RYC_ASSERT_IMPLY(a_latency, clk, rst, !$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4), done == $past(start && !busy, PIPE_DEPTH))

  // nothing comes out right after reset
  `RYC_ASSERT_IMPLY(a_quiet_after_reset, clk, rst, $past(rst, 1), !done)

endmodule

bind rgb_ycbcr_color_converter ryc_checker u_ryc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .pready (pready)
);
